### rtl/core/cfmm_pkg.sv
// ----------------------------------------------------------------------------
// cfmm_pkg: shared types and constants of the circular min/max FIFO
// Queue depth, field widths, operation and status codes, and the structs
// that pass between the sequencer, the compare unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cfmm_pkg;

   localparam int DEPTH  = 8;
   localparam int WORD_W = 32;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OCC_W  = 4;

   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_REMOVE  = 2'd1,
      MODE_INSPECT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // one step of the shared min/max compare unit
   typedef struct packed {
      logic                     en;
      logic                     first;
      logic signed [WORD_W-1:0] word;
   } scan_ctl_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] greatest_word;
      logic signed [WORD_W-1:0] least_word;
      logic                     has_data;
      logic [OCC_W-1:0]         occupancy;
      logic [1:0]               status;
      logic signed [WORD_W-1:0] removed_word;
   } rsp_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/circular_fifo_min_max_core.sv
// ----------------------------------------------------------------------------
// circular_fifo_min_max_core: circular FIFO with min/max report
// Bounded queue of signed words; every beat inserts, removes or inspects and
// returns occupancy and the least and greatest held word.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req_     in   tuser: mode; tdata: value
//  rsp_     out  tdata: removed_word, status, occupancy, has_data,
//                       least_word, greatest_word
//
//  A new request is taken only once the scan of the previous item, over all
//  slots occupied after its operation, is done and its result is in the
//  output register: the slot memory has one read port and the scan folds one slot per cycle.
//  Reset clears pointers and count; slot contents are not cleared.
//  A stalled result sits in the output register; the next request is
//  accepted meanwhile, and its result waits until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_min_max_core
   import cfmm_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [1:0]   req_tuser,    // [1:0] mode
   input  wire  [31:0]  req_tdata,    // [31:0] value
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [103:0] rsp_tdata     // [31:0] removed_word, [33:32] status,
                                      // [37:34] occupancy, [38] has_data,
                                      // [70:39] least_word,
                                      // [102:71] greatest_word, [103] zero
);

   logic                     seq_idle;
   logic                     seq_done;
   logic                     out_free;
   rsp_type                  seq_rsp;
   scan_ctl_type             scan_ctl;
   logic signed [WORD_W-1:0] unit_least;
   logic signed [WORD_W-1:0] unit_greatest;

   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   assign req_tready = seq_idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   cfmm_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_tvalid && req_tready),
      .item_mode     (req_tuser),
      .item_value    (req_tdata),
      .out_free      (out_free),
      .least_word    (unit_least),
      .greatest_word (unit_greatest),
      .idle          (seq_idle),
      .done          (seq_done),
      .rsp           (seq_rsp),
      .scan_ctl      (scan_ctl)
   );

   cfmm_minmax_unit u_minmax (
      .clock         (clock),
      .ctl           (scan_ctl),
      .least_word    (unit_least),
      .greatest_word (unit_greatest)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (seq_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (seq_done) begin
         rsp_ff <= seq_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   // one item at a time: no second accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item is in progress");

   // an empty queue reports zero bounds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.has_data) |->
         (rsp_ff.least_word == '0 && rsp_ff.greatest_word == '0))
      else $error("bounds not zero on empty queue");

   // scan result is ordered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.has_data) |-> (rsp_ff.least_word <= rsp_ff.greatest_word))
      else $error("least word above greatest word");

   // a refused operation returns no word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK) |-> (rsp_ff.removed_word == '0))
      else $error("removed word set on refused operation");

endmodule

`default_nettype wire

### rtl/core/cfmm_minmax_unit.sv
// ----------------------------------------------------------------------------
// cfmm_minmax_unit: running minimum and maximum
// Folds one stored word per step into the running least and greatest word;
// the first word of a scan restarts both.
// ----------------------------------------------------------------------------
`default_nettype none

module cfmm_minmax_unit
   import cfmm_pkg::*;
(
   input  wire                            clock,
   input  wire scan_ctl_type              ctl,
   output logic signed [WORD_W-1:0]       least_word,
   output logic signed [WORD_W-1:0]       greatest_word
);

   logic signed [WORD_W-1:0] least_ff;
   logic signed [WORD_W-1:0] least_in;
   logic signed [WORD_W-1:0] greatest_ff;
   logic signed [WORD_W-1:0] greatest_in;

   always_comb begin
      least_in    = least_ff;
      greatest_in = greatest_ff;
      if (ctl.first || (ctl.word < least_ff)) begin
         least_in = ctl.word;
      end
      if (ctl.first || (ctl.word > greatest_ff)) begin
         greatest_in = ctl.word;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         least_ff    <= least_in;
         greatest_ff <= greatest_in;
      end
   end

   assign least_word    = least_ff;
   assign greatest_word = greatest_ff;

endmodule

`default_nettype wire

### rtl/core/cfmm_seq.sv
// ----------------------------------------------------------------------------
// cfmm_seq: queue store and operation sequencer
// Holds the slot memory and the pointers, applies one operation, then walks
// the occupied slots one per cycle through the compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cfmm_seq
   import cfmm_pkg::*;
(
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           item_valid,
   input  wire [1:0]                     item_mode,
   input  wire [WORD_W-1:0]              item_value,
   input  wire                           out_free,
   input  wire signed [WORD_W-1:0]       least_word,
   input  wire signed [WORD_W-1:0]       greatest_word,
   output logic                          idle,
   output logic                          done,
   output rsp_type                       rsp,
   output scan_ctl_type                  scan_ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   logic [WORD_W-1:0] mem [DEPTH];

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]  scan_left_ff, scan_left_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_removed_ff, rd_removed_in;
   logic              first_ff, first_in;
   logic [1:0]        mode_ff, mode_in;
   logic [WORD_W-1:0] value_ff, value_in;
   status_type        status_ff, status_in;
   logic [WORD_W-1:0] removed_ff, removed_in;
   logic [WORD_W-1:0] rd_data_ff;

   logic              rd_en;
   logic [PTR_W-1:0]  rd_addr;
   logic              wr_en;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_ptr_in   = scan_ptr_ff;
      scan_left_in  = scan_left_ff;
      rd_removed_in = rd_removed_ff;
      first_in      = first_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      removed_in    = removed_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_ptr_ff;
      wr_en         = 1'b0;
      done          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               mode_in  = item_mode;
               value_in = item_value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in  = STATUS_OK;
            removed_in = '0;
            case (mode_ff)
               MODE_INSERT: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     tail_in  = ptr_next(tail_ff);
                     count_in = count_ff + 1'b1;
                  end
               end
               MODE_REMOVE: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     rd_en         = 1'b1;
                     rd_addr       = head_ff;
                     rd_removed_in = 1'b1;
                     head_in       = ptr_next(head_ff);
                     count_in      = count_ff - 1'b1;
                  end
               end
               default: begin
               end
            endcase
            scan_ptr_in  = head_in;
            scan_left_in = count_in;
            first_in     = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            // capture the removed word when its read returns
            if (rd_valid_ff && rd_removed_ff) begin
               removed_in = rd_data_ff;
            end
            if (rd_valid_ff && !rd_removed_ff) begin
               first_in = 1'b0;
            end
            if (scan_left_ff != '0) begin
               rd_en         = 1'b1;
               rd_addr       = scan_ptr_ff;
               rd_removed_in = 1'b0;
               scan_ptr_in   = ptr_next(scan_ptr_ff);
               scan_left_in  = scan_left_ff - 1'b1;
            end else begin
               // last read data is folded this cycle
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_valid_in = rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
      scan_ptr_ff   <= scan_ptr_in;
      scan_left_ff  <= scan_left_in;
      rd_removed_ff <= rd_removed_in;
      first_ff      <= first_in;
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      removed_ff    <= removed_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign idle = (state_ff == ST_IDLE);

   assign scan_ctl.en    = (state_ff == ST_SCAN) && rd_valid_ff && !rd_removed_ff;
   assign scan_ctl.first = first_ff;
   assign scan_ctl.word  = rd_data_ff;

   always_comb begin
      rsp.removed_word  = removed_ff;
      rsp.status        = status_ff;
      rsp.occupancy     = OCC_W'(count_ff);
      rsp.has_data      = (count_ff != '0);
      rsp.least_word    = rsp.has_data ? least_word : '0;
      rsp.greatest_word = rsp.has_data ? greatest_word : '0;
   end

endmodule

`default_nettype wire
